>>> hdl/bwrp_pkg.sv
// shared types, constants and helpers for the box wall reflection block
`default_nettype none
package bwrp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LEN_W       = 31;
  localparam int MASS_W      = 16;
  localparam int MASS_FRAC   = 8;
  localparam int PRESS_W     = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int AXES        = 3;

  // 2 * m * |v| scaled into Q32.16 over a Q30.32 area
  localparam int PRESS_SHIFT = 1 + 2 * FRAC_BITS - MASS_FRAC;
  localparam int MAG_W       = VALUE_WIDTH;
  localparam int PROD_W      = MASS_W + MAG_W;
  localparam int DIVIDEND_W  = PROD_W + PRESS_SHIFT;
  localparam int AREA_W      = 2 * LEN_W;
  localparam int QUOT_BITS   = PRESS_W;
  localparam int TERMS       = 2 * AXES;

  // input stage, product stage, divider, partial sums, output register
  localparam int PIPE_DEPTH  = QUOT_BITS + 5;

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1) << FRAC_BITS;
  localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = CFG_IDX_W'(2);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t             pos_x;
    value_t             pos_y;
    value_t             pos_z;
    value_t             vel_x;
    value_t             vel_y;
    value_t             vel_z;
    logic [MASS_W-1:0]  particle_mass;
  } particle_t;

  typedef struct packed {
    value_t             new_pos_x;
    value_t             new_pos_y;
    value_t             new_pos_z;
    value_t             new_vel_x;
    value_t             new_vel_y;
    value_t             new_vel_z;
    logic [PRESS_W-1:0] wall_pressure;
  } result_t;

  // position and velocity carried alongside the divider
  typedef struct packed {
    value_t [AXES-1:0] pos;
    value_t [AXES-1:0] vel;
  } motion_t;

  // negate, most negative value goes to most positive
  function automatic value_t neg_sat(input value_t v);
    value_t most_neg;
    most_neg = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    if (v == most_neg) return ~most_neg;
    return -v;
  endfunction

  // magnitude as unsigned, most negative value fits
  function automatic logic [MAG_W-1:0] abs_mag(input value_t v);
    if (v[VALUE_WIDTH-1]) return MAG_W'(-v);
    return MAG_W'(v);
  endfunction

endpackage
`default_nettype wire

>>> hdl/bwrp_div_lane.sv
// pipelined restoring divider, one quotient bit per stage, capped quotient
`default_nettype none
module bwrp_div_lane (
  input  wire logic                             clk,
  input  wire logic [bwrp_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [bwrp_pkg::AREA_W-1:0]      divisor,
  output logic      [bwrp_pkg::PRESS_W-1:0]     quotient
);
  import bwrp_pkg::*;

  logic [AREA_W-1:0]    rem  [QUOT_BITS+1];
  logic [PRESS_W-1:0]   low  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo  [QUOT_BITS+1];
  logic [AREA_W-1:0]    den  [QUOT_BITS+1];
  logic                 sat  [QUOT_BITS+1];
  logic                 zero [QUOT_BITS+1];

  // entry: quotient overflows when the upper dividend part reaches the divisor
  always_ff @(posedge clk) begin
    rem[0]  <= AREA_W'(dividend[DIVIDEND_W-1:PRESS_W]);
    low[0]  <= dividend[PRESS_W-1:0];
    quo[0]  <= '0;
    den[0]  <= divisor;
    sat[0]  <= AREA_W'(dividend[DIVIDEND_W-1:PRESS_W]) >= divisor;
    zero[0] <= dividend == '0;
  end

  // one shift, compare and subtract per stage
  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
    logic [AREA_W:0] rem2;
    logic [AREA_W:0] diff;
    logic            ge;
    assign rem2 = {rem[i], low[i][PRESS_W-1]};
    assign diff = rem2 - {1'b0, den[i]};
    assign ge   = rem2 >= {1'b0, den[i]};
    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? diff[AREA_W-1:0] : rem2[AREA_W-1:0];
      low[i+1]  <= {low[i][PRESS_W-2:0], 1'b0};
      quo[i+1]  <= {quo[i][QUOT_BITS-2:0], ge};
      den[i+1]  <= den[i];
      sat[i+1]  <= sat[i];
      zero[i+1] <= zero[i];
    end
  end

  // zero product gives zero, overflow or zero area gives the cap
  assign quotient = zero[QUOT_BITS] ? '0 :
                    sat[QUOT_BITS]  ? PRESS_MAX : quo[QUOT_BITS];

endmodule
`default_nettype wire

>>> hdl/box_wall_reflection_pressure.sv
// top level: wall reflection of one particle in a box with wall pressure
//
// One particle word is taken every clock cycle; busy never rises and
// cfg_ready stays high. Each result word appears on result with done high
// for exactly one cycle, and the receiver cannot stall it. The result path
// runs through the six pipelined divider lanes (one quotient bit per stage
// over 48 stages) plus input, product, divider entry, partial sum and
// saturating total stages. Box lengths may only be changed while no word
// is in flight.
`default_nettype none
module box_wall_reflection_pressure (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire bwrp_pkg::particle_t               particle,
  output logic                                   done,
  output bwrp_pkg::result_t                      result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bwrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bwrp_pkg::LEN_W-1:0]        cfg_data
);
  import bwrp_pkg::*;

  logic [LEN_W-1:0] box_len [AXES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) box_len[a] <= LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BOX_X: box_len[0] <= cfg_data;
        CFG_BOX_Y: box_len[1] <= cfg_data;
        CFG_BOX_Z: box_len[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the word
  logic [PIPE_DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[PIPE_DEPTH-2:0], start};
  end

  // stage 1: wall tests, clamping, sign flips, hit magnitudes
  value_t           pin [AXES];
  value_t           vin [AXES];
  motion_t          mot_next;
  logic [MAG_W-1:0] mag_next [TERMS];

  assign pin[0] = particle.pos_x;
  assign pin[1] = particle.pos_y;
  assign pin[2] = particle.pos_z;
  assign vin[0] = particle.vel_x;
  assign vin[1] = particle.vel_y;
  assign vin[2] = particle.vel_z;

  always_comb begin
    logic   far_hit;
    logic   near_hit;
    value_t lenv;
    value_t v1;
    for (int a = 0; a < AXES; a++) begin
      lenv     = value_t'({1'b0, box_len[a]});
      far_hit  = pin[a] >= lenv;
      near_hit = far_hit ? (box_len[a] == '0) : (pin[a] <= 0);
      v1       = far_hit ? neg_sat(vin[a]) : vin[a];
      mot_next.vel[a] = near_hit ? neg_sat(v1) : v1;
      mot_next.pos[a] = near_hit ? '0 : (far_hit ? lenv : pin[a]);
      mag_next[2*a]   = far_hit ? abs_mag(vin[a]) : '0;
      mag_next[2*a+1] = near_hit ? abs_mag(v1) : '0;
    end
  end

  motion_t          mot [PIPE_DEPTH];
  logic [MAG_W-1:0] mag [TERMS];
  logic [MASS_W-1:0] mass1;
  logic [LEN_W-1:0] len1 [AXES];

  always_ff @(posedge clk) begin
    mot[0] <= mot_next;
    mass1  <= particle.particle_mass;
    for (int k = 0; k < TERMS; k++) mag[k] <= mag_next[k];
    for (int a = 0; a < AXES; a++) len1[a] <= box_len[a];
  end

  // motion delay line alongside the dividers
  for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_delay
    always_ff @(posedge clk) mot[k] <= mot[k-1];
  end

  // stage 2: momentum products and wall areas
  logic [PROD_W-1:0] prod [TERMS];
  logic [AREA_W-1:0] area [AXES];
  always_ff @(posedge clk) begin
    for (int k = 0; k < TERMS; k++) prod[k] <= mass1 * mag[k];
    area[0] <= len1[1] * len1[2];
    area[1] <= len1[0] * len1[2];
    area[2] <= len1[0] * len1[1];
  end

  // divider lanes, two per axis
  logic [PRESS_W-1:0] term [TERMS];
  for (genvar k = 0; k < TERMS; k++) begin : g_lane
    bwrp_div_lane u_lane (
      .clk      (clk),
      .dividend ({prod[k], {PRESS_SHIFT{1'b0}}}),
      .divisor  (area[k/2]),
      .quotient (term[k])
    );
  end

  // partial sums, then saturating total
  logic [PRESS_W:0]   psum [AXES];
  logic [PRESS_W+2:0] total;
  logic [PRESS_W-1:0] press;

  assign total = (PRESS_W+3)'(psum[0]) + (PRESS_W+3)'(psum[1]) + (PRESS_W+3)'(psum[2]);

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      psum[a] <= (PRESS_W+1)'(term[2*a]) + (PRESS_W+1)'(term[2*a+1]);
    end
    press <= (total > (PRESS_W+3)'(PRESS_MAX)) ? PRESS_MAX : total[PRESS_W-1:0];
  end

  // result word
  assign done                 = vld[PIPE_DEPTH-1];
  assign result.new_pos_x     = mot[PIPE_DEPTH-1].pos[0];
  assign result.new_pos_y     = mot[PIPE_DEPTH-1].pos[1];
  assign result.new_pos_z     = mot[PIPE_DEPTH-1].pos[2];
  assign result.new_vel_x     = mot[PIPE_DEPTH-1].vel[0];
  assign result.new_vel_y     = mot[PIPE_DEPTH-1].vel[1];
  assign result.new_vel_z     = mot[PIPE_DEPTH-1].vel[2];
  assign result.wall_pressure = press;

endmodule
`default_nettype wire
